>>> rtl/rlfo_pkg.sv
// Shared types and fixed-format constants for the random LFO modulator.
package rlfo_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_FREQ = 2'd1;
    localparam logic [1:0] CFG_SEED = 2'd2;

    // Mode codes
    localparam logic [1:0] MODE_SMOOTH = 2'd0;
    localparam logic [1:0] MODE_HOLD   = 2'd1;
    localparam logic [1:0] MODE_BINARY = 2'd2;

    // Port widths fixed by the field formats
    localparam int CFG_DATA_BITS = 32;
    localparam int FREQ_BITS     = 24;
    localparam int TIME_BITS     = 24;
    localparam int OUT_BITS      = 16;
    localparam int PHASE_OUT     = 24;
    localparam int LFSR_BITS     = 32;

    // Serial multiplier: multiplier operand width, retired two bits per cycle
    localparam int MUL_BW = 24;

    // Q12.12 frequency times Q0.24 time gives a Q12.36 product
    localparam int PROD_FRAC = 36;
    localparam int PROD_TOP  = FREQ_BITS + TIME_BITS - 1;

    // Smoothstep works on a Q0.16 phase
    localparam int Q_BITS = 16;
    localparam int S_BITS = 17;
    localparam int T_BITS = 18;
    localparam logic [T_BITS-1:0] SMOOTH_THREE = 18'h30000;

    // Control word from the sequencer to the random number unit
    typedef struct packed {
        logic seed_load;
        logic start;
        logic commit;
    } t_lfsr_ctl;

endpackage

>>> rtl/rlfo_mul.sv
// Radix-4 shift-add multiplier: signed multiplicand, unsigned multiplier, two bits per cycle.
module rlfo_mul
    import rlfo_pkg::*;
#(
    parameter int AW = 26,
    parameter int BW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [AW-1:0]        i_a,
    input  logic [BW-1:0]        i_b,
    output logic                 o_busy,
    output logic [AW+BW-1:0]     o_product
);

    localparam int STEPS = BW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [AW-1:0] r_a;
    logic [AW:0]   r_hi;
    logic [BW-1:0] r_lo;
    logic [CW-1:0] r_cnt;

    logic [AW+2:0] pp1;
    logic [AW+2:0] pp2;
    logic [AW+2:0] sum;

    // Partial products for the low digit of the multiplier, added to the running high half.
    always_comb begin
        pp1 = r_lo[0] ? {{3{r_a[AW-1]}}, r_a} : '0;
        pp2 = r_lo[1] ? {{2{r_a[AW-1]}}, r_a, 1'b0} : '0;
        sum = {{2{r_hi[AW]}}, r_hi} + pp1 + pp2;
    end

    // Each step shifts the product right by one digit; low product bits replace used digits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_cnt != '0) begin
            r_hi <= sum[AW+2:2];
            r_lo <= {sum[1:0], r_lo[BW-1:2]};
        end
    end

    assign o_busy    = (r_cnt != '0);
    assign o_product = {r_hi[AW-1:0], r_lo};

endmodule

>>> rtl/rlfo_lfsr.sv
// Galois LFSR that steps a working copy one bit per cycle and commits it on request.
module rlfo_lfsr
    import rlfo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lfsr_ctl            i_ctl,
    input  logic [LFSR_BITS-1:0] i_seed,
    output logic                 o_busy,
    output logic [LFSR_BITS-1:0] o_draw
);

    localparam logic [LFSR_BITS-1:0] TAPS = 32'h8020_0003;
    localparam int STEPS = LFSR_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [LFSR_BITS-1:0] r_state;
    logic [LFSR_BITS-1:0] r_work;
    logic [CW-1:0]        r_cnt;

    logic [LFSR_BITS-1:0] step;

    // One shift to the right, folding the taps back in when a one falls out.
    always_comb begin
        step = {1'b0, r_work[LFSR_BITS-1:1]};
        if (r_work[0]) begin
            step = step ^ TAPS;
        end
    end

    // Committed state: a seed write loads it directly, a zero seed becomes one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LFSR_BITS'(1);
        end else if (i_ctl.seed_load) begin
            r_state <= (i_seed == '0) ? LFSR_BITS'(1) : i_seed;
        end else if (i_ctl.commit) begin
            r_state <= r_work;
        end
    end

    // Working copy runs a full word of steps after each start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= CW'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_work <= r_state;
        end else if (r_cnt != '0) begin
            r_work <= step;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_draw = r_work;

endmodule

>>> rtl/random_lfo_modulator.sv
// Random LFO top level: sequencer, phase accumulator, smoothing and output register.
// The time from an accepted word to its result word is set by four passes of the shared
// radix-4 multiplier in smooth mode, or by the 32 single-bit steps of the random shift
// register in the other modes. A new word is taken only in idle, so one word is in flight
// at a time; a stalled output holds the sequencer. Synchronous active-low reset clears
// phase and the current and target values, loads mode 0, 1 Hz and seed 1.
module random_lfo_modulator
    import rlfo_pkg::*;
#(
    parameter int PHASE_BITS = 24,
    parameter int VALUE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [TIME_BITS-1:0]     i_elapsed_time,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [OUT_BITS-1:0] o_value,
    output logic [PHASE_OUT-1:0]     o_phase_now,
    output logic                     o_wrapped
);

    localparam int PB     = PHASE_BITS;
    localparam int VB     = VALUE_BITS;
    localparam int MUL_AW = (VB + 2 > 26) ? VB + 2 : 26;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL1    = 4'd1;
    localparam logic [3:0] S_EVAL    = 4'd2;
    localparam logic [3:0] S_MUL2    = 4'd3;
    localparam logic [3:0] S_MUL3    = 4'd4;
    localparam logic [3:0] S_DRAW    = 4'd5;
    localparam logic [3:0] S_MUL4_GO = 4'd6;
    localparam logic [3:0] S_MUL4    = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    logic [3:0]           r_state,     n_state;
    logic [1:0]           r_mode,      n_mode;
    logic [FREQ_BITS-1:0] r_freq,      n_freq;
    logic [PB-1:0]        r_phase,     n_phase;
    logic                 r_wrapped,   n_wrapped;
    logic [VB-1:0]        r_cur,       n_cur;
    logic [VB-1:0]        r_tgt,       n_tgt;
    logic [S_BITS-1:0]    r_s,         n_s;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]  r_value,     n_value;
    logic [PHASE_OUT-1:0] r_phase_out, n_phase_out;
    logic                 r_wrap_out,  n_wrap_out;

    logic                 mul_start;
    logic [MUL_AW-1:0]    mul_a;
    logic [MUL_BW-1:0]    mul_b;
    logic                 mul_busy;
    logic [MUL_PW-1:0]    mul_p;

    t_lfsr_ctl            lfsr_ctl;
    logic                 lfsr_busy;
    logic [LFSR_BITS-1:0] lfsr_draw;

    logic                 in_accept;
    logic                 out_load;
    logic [PB-1:0]        inc;
    logic [PB:0]          phase_sum;
    logic [Q_BITS-1:0]    q;
    logic [T_BITS-1:0]    t;
    logic [VB:0]          diff;
    logic [VB:0]          v_wide;
    logic [VB-1:0]        v_sel;
    logic [OUT_BITS-1:0]  v_q15;
    logic [PHASE_OUT-1:0] phase_fmt;
    logic [VB-1:0]        uniform;
    logic [VB-1:0]        binary;

    rlfo_mul #(
        .AW (MUL_AW),
        .BW (MUL_BW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_busy    (mul_busy),
        .o_product (mul_p)
    );

    rlfo_lfsr u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lfsr_ctl),
        .i_seed  (i_cfg_data[LFSR_BITS-1:0]),
        .o_busy  (lfsr_busy),
        .o_draw  (lfsr_draw)
    );

    // Phase formats: Q0.16 for smoothstep and Q0.24 for the result word.
    generate
        if (PB >= Q_BITS) begin : g_q_trunc
            assign q = r_phase[PB-1 -: Q_BITS];
        end else begin : g_q_pad
            assign q = {r_phase, {(Q_BITS - PB){1'b0}}};
        end
        if (PB >= PHASE_OUT) begin : g_ph_trunc
            assign phase_fmt = r_phase[PB-1 -: PHASE_OUT];
        end else begin : g_ph_pad
            assign phase_fmt = {r_phase, {(PHASE_OUT - PB){1'b0}}};
        end
        if (VB >= OUT_BITS) begin : g_v_trunc
            assign v_q15 = v_sel[VB-1 -: OUT_BITS];
        end else begin : g_v_pad
            assign v_q15 = {v_sel, {(OUT_BITS - VB){1'b0}}};
        end
    endgenerate

    // Phase increment clamps just below a full cycle; the carry out of the add is the wrap.
    always_comb begin
        inc       = (|mul_p[PROD_TOP:PROD_FRAC]) ? '1 : mul_p[PROD_FRAC-1 -: PB];
        phase_sum = {1'b0, r_phase} + {1'b0, inc};
        t         = SMOOTH_THREE - {1'b0, q, 1'b0};
        diff      = {r_tgt[VB-1], r_tgt} - {r_cur[VB-1], r_cur};
        v_wide    = {r_cur[VB-1], r_cur} + mul_p[Q_BITS +: VB + 1];
        uniform   = lfsr_draw[LFSR_BITS-1 -: VB];
        binary    = {~lfsr_draw[0], {(VB - 1){lfsr_draw[0]}}};
    end

    // Output value by mode; the unused mode reads as zero.
    always_comb begin
        case (r_mode)
            MODE_SMOOTH: v_sel = v_wide[VB-1:0];
            MODE_HOLD:   v_sel = r_cur;
            MODE_BINARY: v_sel = r_cur;
            default:     v_sel = '0;
        endcase
    end

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Sequencer, configuration writes and output register control.
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_freq      = r_freq;
        n_phase     = r_phase;
        n_wrapped   = r_wrapped;
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_s         = r_s;
        n_value     = r_value;
        n_phase_out = r_phase_out;
        n_wrap_out  = r_wrap_out;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        lfsr_ctl    = '0;
        out_load    = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE: n_mode = i_cfg_data[1:0];
                CFG_FREQ: n_freq = i_cfg_data[FREQ_BITS-1:0];
                CFG_SEED: lfsr_ctl.seed_load = 1'b1;
                default:  ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    mul_start      = 1'b1;
                    mul_a          = {{(MUL_AW - FREQ_BITS){1'b0}}, r_freq};
                    mul_b          = i_elapsed_time;
                    lfsr_ctl.start = 1'b1;
                    n_state        = S_MUL1;
                end
            end
            S_MUL1: begin
                if (!mul_busy) begin
                    n_phase   = phase_sum[PB-1:0];
                    n_wrapped = phase_sum[PB];
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_mode == MODE_SMOOTH) begin
                    mul_start = 1'b1;
                    mul_a     = {{(MUL_AW - Q_BITS){1'b0}}, q};
                    mul_b     = {{(MUL_BW - Q_BITS){1'b0}}, q};
                    n_state   = S_MUL2;
                end else begin
                    n_state = S_DRAW;
                end
            end
            S_MUL2: begin
                // Square is ready: scale it by three minus twice the phase.
                if (!mul_busy) begin
                    mul_start = 1'b1;
                    mul_a     = {{(MUL_AW - Q_BITS){1'b0}}, mul_p[Q_BITS +: Q_BITS]};
                    mul_b     = {{(MUL_BW - T_BITS){1'b0}}, t};
                    n_state   = S_MUL3;
                end
            end
            S_MUL3: begin
                if (!mul_busy) begin
                    n_s     = mul_p[Q_BITS +: S_BITS];
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                // On a wrap the stepped register supplies the new random value.
                if (!lfsr_busy) begin
                    if (r_wrapped) begin
                        case (r_mode)
                            MODE_SMOOTH: begin
                                n_cur           = r_tgt;
                                n_tgt           = uniform;
                                lfsr_ctl.commit = 1'b1;
                            end
                            MODE_HOLD: begin
                                n_cur           = uniform;
                                lfsr_ctl.commit = 1'b1;
                            end
                            MODE_BINARY: begin
                                n_cur           = binary;
                                lfsr_ctl.commit = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    n_state = (r_mode == MODE_SMOOTH) ? S_MUL4_GO : S_OUT;
                end
            end
            S_MUL4_GO: begin
                mul_start = 1'b1;
                mul_a     = {{(MUL_AW - VB - 1){diff[VB]}}, diff};
                mul_b     = {{(MUL_BW - S_BITS){1'b0}}, r_s};
                n_state   = S_MUL4;
            end
            S_MUL4: begin
                if (!mul_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_value     = v_q15;
                    n_phase_out = phase_fmt;
                    n_wrap_out  = r_wrapped;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_SMOOTH;
            r_freq      <= FREQ_BITS'(4096);
            r_phase     <= '0;
            r_cur       <= '0;
            r_tgt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_freq      <= n_freq;
            r_phase     <= n_phase;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_wrapped   <= n_wrapped;
        r_s         <= n_s;
        r_value     <= n_value;
        r_phase_out <= n_phase_out;
        r_wrap_out  <= n_wrap_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_phase_now = r_phase_out;
    assign o_wrapped   = r_wrap_out;

`ifndef NO_ASSERTIONS
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lfsr_ctl.commit |-> (!lfsr_busy && r_wrapped))
        else $error("random register committed while stepping or without a wrap");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result word overwritten while stalled");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mul_busy)
        else $error("multiplier still running in idle");
`endif

endmodule

>>> sim/random_lfo_modulator_tb.sv
// Self-checking testbench for the random LFO modulator, with a built-in tick predictor.
`timescale 1ns / 1ps

module random_lfo_modulator_tb
    import rlfo_pkg::*;
();

    // Codes the package leaves unnamed, and testbench constants
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [1:0]  CFG_NONE    = 2'd3;
    localparam logic [31:0] LFSR_TAPS   = 32'h80200003;
    localparam logic [23:0] TIME_MAX    = 24'hFFFFFF;
    localparam logic [23:0] FREQ_MAX    = 24'hFFFFFF;
    localparam logic [23:0] FREQ_1HZ    = 24'd4096;
    localparam int RANDOM_TICKS = 1850;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_CYCLES = 100;
    localparam longint LIMIT_NS = 64'd16_000_000;

    typedef struct {
        logic signed [OUT_BITS-1:0] value;
        logic [PHASE_OUT-1:0]       phase_now;
        logic                       wrapped;
    } t_lfo_sample;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [1:0]                 i_cfg_index;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [TIME_BITS-1:0]       i_elapsed_time;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [OUT_BITS-1:0] o_value;
    logic [PHASE_OUT-1:0]       o_phase_now;
    logic                       o_wrapped;

    random_lfo_modulator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_elapsed_time (i_elapsed_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value        (o_value),
        .o_phase_now    (o_phase_now),
        .o_wrapped      (o_wrapped)
    );

    // Predicted modulator state and registers
    logic [1:0]                 lfo_mode;
    logic [FREQ_BITS-1:0]       lfo_freq;
    logic [23:0]                lfo_phase;
    logic signed [15:0]         lfo_cur;
    logic signed [15:0]         lfo_tgt;
    logic [LFSR_BITS-1:0]       lfo_lfsr;

    t_lfo_sample pending_samples[$];

    int errors = 0;
    int ticks_sent = 0;
    int samples_checked = 0;
    int wraps_seen = 0;
    int reg_writes = 0;
    int mode_ticks[4] = '{0, 0, 0, 0};
    int burst_left = 0;

    // Receiver stall pattern state
    int  stall_style = 0;
    int  style_left = 0;
    int  run_left = 0;
    logic run_stall = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timed out with %0d words still expected.", pending_samples.size());
        $display("FAIL random_lfo_modulator");
        $finish;
    end

    // Step the shift register through one full 32-bit draw.
    function automatic logic [31:0] lfsr_draw(input logic [31:0] s);
        for (int i = 0; i < 32; i++) begin
            s = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
        end
        return s;
    endfunction

    task automatic model_reset();
        lfo_mode  = MODE_SMOOTH;
        lfo_freq  = FREQ_1HZ;
        lfo_phase = '0;
        lfo_cur   = '0;
        lfo_tgt   = '0;
        lfo_lfsr  = 32'd1;
    endtask

    task automatic model_write(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_MODE: lfo_mode = data[1:0];
            CFG_FREQ: lfo_freq = data[23:0];
            CFG_SEED: lfo_lfsr = (data == 32'd0) ? 32'd1 : data;
            default: ;
        endcase
    endtask

    // Advance the predicted phase by one tick and evaluate the output word.
    task automatic predict_tick(input logic [23:0] elapsed, output t_lfo_sample w);
        logic [47:0] prod;
        logic [35:0] inc;
        logic [24:0] sum;
        longint q, q2, s, diff, v;
        prod = lfo_freq * elapsed;
        inc = prod[47:12];
        if (inc > 36'hFFFFFF) inc = 36'hFFFFFF;
        sum = {1'b0, lfo_phase} + inc[24:0];
        lfo_phase = sum[23:0];
        w.wrapped = sum[24];
        if (sum[24]) begin
            wraps_seen++;
            case (lfo_mode)
                MODE_SMOOTH: begin
                    lfo_cur  = lfo_tgt;
                    lfo_lfsr = lfsr_draw(lfo_lfsr);
                    lfo_tgt  = $signed(lfo_lfsr[31:16]);
                end
                MODE_HOLD: begin
                    lfo_lfsr = lfsr_draw(lfo_lfsr);
                    lfo_cur  = $signed(lfo_lfsr[31:16]);
                end
                MODE_BINARY: begin
                    lfo_lfsr = lfsr_draw(lfo_lfsr);
                    lfo_cur  = lfo_lfsr[0] ? 16'sd32767 : -16'sd32768;
                end
                default: ;
            endcase
        end
        // Smoothstep blend on a Q0.16 phase, floor division throughout
        case (lfo_mode)
            MODE_SMOOTH: begin
                q    = longint'(lfo_phase[23:8]);
                q2   = (q * q) >> 16;
                s    = (q2 * (longint'(196608) - 2 * q)) >> 16;
                diff = longint'(lfo_tgt) - longint'(lfo_cur);
                v    = longint'(lfo_cur) + ((diff * s) >>> 16);
            end
            MODE_HOLD, MODE_BINARY: v = longint'(lfo_cur);
            default: v = 0;
        endcase
        w.value = v[15:0];
        w.phase_now = lfo_phase;
        mode_ticks[lfo_mode]++;
    endtask

    // Offer one word, wait for it to be taken, then maybe open an idle gap.
    task automatic send_tick(input logic [23:0] elapsed);
        t_lfo_sample w;
        i_in_valid <= 1'b1;
        i_elapsed_time <= elapsed;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_tick(elapsed, w);
        pending_samples.push_back(w);
        ticks_sent++;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end else begin
            burst_left--;
        end
    endtask

    // Let every outstanding word drain and the block go quiet.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_write(idx, data);
        reg_writes++;
    endtask

    // Elapsed time mostly sized to give a handful of ticks per cycle, plus noise.
    function automatic logic [23:0] pick_elapsed();
        int r;
        longint per_cycle, want_inc, e;
        r = $urandom_range(0, 99);
        if (r < 70 && lfo_freq != 0) begin
            per_cycle = $urandom_range(1, 24);
            want_inc = (longint'(1) << 24) / per_cycle + $urandom_range(0, 4095) - 2048;
            if (want_inc < 0) want_inc = 0;
            e = (want_inc << 12) / longint'(lfo_freq);
            if (e > longint'(TIME_MAX)) e = longint'(TIME_MAX);
            return e[23:0];
        end else if (r < 85) begin
            return 24'($urandom());
        end else if (r < 93) begin
            return 24'($urandom_range(0, 1023));
        end
        return ($urandom_range(0, 1) == 0) ? 24'd0 : TIME_MAX;
    endfunction

    function automatic logic [23:0] pick_freq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 24'd0;
        if (r < 12) return FREQ_MAX;
        if (r < 45) return 24'($urandom_range(1, 4096));
        if (r < 75) return 24'($urandom_range(4096, 1 << 18));
        return 24'($urandom());
    endfunction

    // Checker on accepted output words, plus the receiver's stall pattern.
    always @(posedge i_clk) begin
        t_lfo_sample want;
        logic stall_next;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected word: value %0d phase %h wrapped %b",
                         $time, o_value, o_phase_now, o_wrapped);
                errors++;
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (o_value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d got %0d",
                             $time, want.value, o_value);
                    errors++;
                end
                if (o_phase_now !== want.phase_now) begin
                    $display("%0t: phase mismatch, expected %h got %h",
                             $time, want.phase_now, o_phase_now);
                    errors++;
                end
                if (o_wrapped !== want.wrapped) begin
                    $display("%0t: wrap flag mismatch, expected %b got %b",
                             $time, want.wrapped, o_wrapped);
                    errors++;
                end
            end
        end
        // Switch between no stall, light, heavy and long-run stalling.
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(50, 600);
        end else begin
            style_left--;
        end
        case (stall_style)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 3) == 0);
            2: stall_next = ($urandom_range(0, 1) == 0);
            default: begin
                if (run_left == 0) begin
                    run_stall = ~run_stall;
                    run_left = $urandom_range(1, 16);
                end else begin
                    run_left--;
                end
                stall_next = run_stall;
            end
        endcase
        i_out_stall <= stall_next;
    end

    // Default registers: smooth noise at 1 Hz, where elapsed time equals the increment.
    task automatic test_reset_defaults();
        send_tick(24'd0);
        send_tick(TIME_MAX);
        send_tick(24'd1);
        send_tick(24'h800000);
    endtask

    // Frequency and elapsed time at their extremes, including the clamped increment.
    task automatic test_field_extremes();
        write_reg(CFG_FREQ, 32'd0);
        send_tick(TIME_MAX);
        write_reg(CFG_FREQ, {8'hFF, FREQ_MAX});
        send_tick(TIME_MAX);
        send_tick(24'd1);
        send_tick(24'd0);
    endtask

    // Hold and binary modes in turn, the unused mode and a mode write with stray upper bits.
    task automatic test_each_mode();
        write_reg(CFG_FREQ, 32'h0C0000);
        write_reg(CFG_MODE, {30'h3FFFFFFF, MODE_HOLD});
        repeat (3) send_tick(24'h600000);
        write_reg(CFG_MODE, {30'd0, MODE_BINARY});
        repeat (3) send_tick(24'h600000);
        write_reg(CFG_MODE, {30'd0, MODE_UNUSED});
        repeat (3) send_tick(24'h600000);
    endtask

    // A zero seed loads as one; the largest seed; a write to the unused index is ignored.
    task automatic test_seed_and_index();
        write_reg(CFG_MODE, {30'd0, MODE_HOLD});
        write_reg(CFG_SEED, 32'd0);
        repeat (2) send_tick(24'hA00000);
        write_reg(CFG_SEED, 32'hFFFFFFFF);
        repeat (2) send_tick(24'hA00000);
        write_reg(CFG_NONE, $urandom());
        write_reg(CFG_MODE, {30'd0, MODE_SMOOTH});
        repeat (2) send_tick(24'hA00000);
    endtask

    // Random settings per phase, mostly well-paced ticks within each phase.
    task automatic test_random_phases();
        int goal, phase_len, r;
        goal = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 35) write_reg(CFG_MODE, {30'($urandom_range(0, 1 << 29)), MODE_SMOOTH});
            else if (r < 62) write_reg(CFG_MODE, {30'd0, MODE_HOLD});
            else if (r < 90) write_reg(CFG_MODE, {30'd0, MODE_BINARY});
            else write_reg(CFG_MODE, {30'd0, MODE_UNUSED});
            write_reg(CFG_FREQ, {8'($urandom()), pick_freq()});
            r = $urandom_range(0, 9);
            if (r < 3) write_reg(CFG_SEED, $urandom());
            else if (r == 3) write_reg(CFG_SEED, 32'd0);
            else if (r == 4) write_reg(CFG_SEED, 32'hFFFFFFFF);
            phase_len = $urandom_range(40, 110);
            repeat (phase_len) send_tick(pick_elapsed());
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_MODE;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_elapsed_time <= '0;
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_each_mode();
        test_seed_and_index();
        test_random_phases();

        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d ticks, checked %0d output words, %0d wraps, %0d register writes.",
                 ticks_sent, samples_checked, wraps_seen, reg_writes);
        $display("Ticks by mode: smooth %0d, hold %0d, binary %0d, unused %0d.",
                 mode_ticks[0], mode_ticks[1], mode_ticks[2], mode_ticks[3]);
        if (errors == 0 && pending_samples.size() == 0) begin
            $display("PASS random_lfo_modulator");
        end else begin
            $display("%0d mismatches, %0d words never arrived.", errors, pending_samples.size());
            $display("FAIL random_lfo_modulator");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rlfo_pkg.sv
rtl/rlfo_mul.sv
rtl/rlfo_lfsr.sv
rtl/random_lfo_modulator.sv
sim/random_lfo_modulator_tb.sv
